// File: design/lld_pkg.sv
package lld_pkg;

   localparam int MAX_WORKERS = 8;

   localparam logic [3:0] ACTIVE_RESET = 4'd8;

   typedef enum logic {
      KIND_REQUEST = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_IDLE      = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] worker;
   } req_type;

   typedef struct packed {
      logic [2:0] granted_worker;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic inc;
      logic dec;
   } cell_ctl_type;

endpackage

// File: design/lld_cell.sv
module lld_cell
   import lld_pkg::*;
#(
   parameter int CW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic          member,
   input  logic          hit,
   input  logic [CW-1:0] next_count,
   output logic [CW-1:0] count
);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (ctl.shift && member) begin
         count_in = next_count;
      end else if (hit && ctl.inc) begin
         count_in = count_ff + CW'(1);
      end else if (hit && ctl.dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// File: design/least_loaded_worker_dispatcher.sv
// Each request or release item passes through a prep, a scan and a write-back state from
// acceptance to a registered result. In the prep state the rotation pointer is reduced
// below N, the number of active workers, by as many subtractions of N as it needs after
// the active count has been lowered. In the scan state the per-worker counts circulate
// once around the ring of cells past the head cell, and the write-back state waits while
// an earlier result is still held. Once the result is registered, the next item can be
// accepted even if that result has not yet been taken.
module least_loaded_worker_dispatcher
   import lld_pkg::*;
#(
   parameter int MAX_OUTSTANDING = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   localparam int WIDX = $clog2(MAX_WORKERS);
   localparam int NW   = $clog2(MAX_WORKERS + 1);
   localparam int CW   = $clog2(MAX_OUTSTANDING + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PREP = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [3:0]      active_ff, active_in;
   logic [WIDX-1:0] ptr_ff, ptr_in;
   logic [WIDX-1:0] start_ff, start_in;
   logic [WIDX-1:0] scan_ff, scan_in;
   kind_type        kind_ff, kind_in;
   logic [2:0]      worker_ff, worker_in;
   logic [CW-1:0]   best_count_ff, best_count_in;
   logic [WIDX-1:0] best_rel_ff, best_rel_in;
   logic [WIDX-1:0] best_idx_ff, best_idx_in;
   logic [CW-1:0]   rel_count_ff, rel_count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic [NW-1:0]   n_eff;
   logic [WIDX-1:0] n_last;
   logic [NW-1:0]   rel_wide;
   logic [WIDX-1:0] rel;
   logic [WIDX-1:0] target;
   logic            done_fire;
   cell_ctl_type    ctl;
   logic [CW-1:0]   count [MAX_WORKERS];
   logic [CW-1:0]   head;

   always_comb begin
      if (active_ff == 4'd0) begin
         n_eff = NW'(1);
      end else if (32'(active_ff) > 32'(MAX_WORKERS)) begin
         n_eff = NW'(MAX_WORKERS);
      end else begin
         n_eff = NW'(active_ff);
      end
   end

   assign n_last    = WIDX'(n_eff - NW'(1));
   assign head      = count[0];
   assign done_fire = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rel_wide = NW'(scan_ff) - NW'(start_ff);
      if (scan_ff < start_ff) begin
         rel_wide = rel_wide + n_eff;
      end
      rel = WIDX'(rel_wide);
   end

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      ptr_in        = ptr_ff;
      start_in      = start_ff;
      scan_in       = scan_ff;
      kind_in       = kind_ff;
      worker_in     = worker_ff;
      best_count_in = best_count_ff;
      best_rel_in   = best_rel_ff;
      best_idx_in   = best_idx_ff;
      rel_count_in  = rel_count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ctl           = '0;
      target        = best_idx_ff;

      if (csr_valid) begin
         active_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.kind;
               worker_in = req_data.worker;
               start_in  = ptr_ff;
               scan_in   = '0;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            if (32'(start_ff) >= 32'(n_eff)) begin
               start_in = WIDX'(NW'(start_ff) - n_eff);
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.shift = 1'b1;
            if (scan_ff == '0 || head < best_count_ff ||
                (head == best_count_ff && rel < best_rel_ff)) begin
               best_count_in = head;
               best_rel_in   = rel;
               best_idx_in   = scan_ff;
            end
            if (32'(scan_ff) == 32'(worker_ff)) begin
               rel_count_in = head;
            end
            if (scan_ff == n_last) begin
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + WIDX'(1);
            end
         end
         S_DONE: begin
            if (done_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (kind_ff == KIND_REQUEST) begin
                  rsp_data_in.granted_worker = 3'(best_idx_ff);
                  if (32'(best_count_ff) >= 32'(MAX_OUTSTANDING)) begin
                     rsp_data_in.status = STATUS_SATURATED;
                  end else begin
                     rsp_data_in.status = STATUS_OK;
                     ctl.inc            = 1'b1;
                     if (start_ff == n_last) begin
                        ptr_in = '0;
                     end else begin
                        ptr_in = start_ff + WIDX'(1);
                     end
                  end
               end else begin
                  rsp_data_in.granted_worker = 3'd0;
                  target                     = WIDX'(worker_ff);
                  if (32'(worker_ff) >= 32'(n_eff)) begin
                     rsp_data_in.status = STATUS_BAD_INDEX;
                  end else if (rel_count_ff == '0) begin
                     rsp_data_in.status = STATUS_IDLE;
                  end else begin
                     rsp_data_in.status = STATUS_OK;
                     ctl.dec            = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
      logic          member;
      logic          hit;
      logic [CW-1:0] next_count;

      assign member = 32'(i) < 32'(n_eff);
      assign hit    = 32'(target) == 32'(i);
      if (i == MAX_WORKERS - 1) begin : g_wrap
         assign next_count = count[0];
      end else begin : g_link
         assign next_count = (32'(i) == 32'(n_last)) ? count[0] : count[i + 1];
      end

      lld_cell #(
         .CW (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .member     (member),
         .hit        (hit),
         .next_count (next_count),
         .count      (count[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= ACTIVE_RESET;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      scan_ff       <= scan_in;
      kind_ff       <= kind_in;
      worker_ff     <= worker_in;
      best_count_ff <= best_count_in;
      best_rel_ff   <= best_rel_in;
      best_idx_ff   <= best_idx_in;
      rel_count_ff  <= rel_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// File: design/lld_checker.sv
module lld_checker
   import lld_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input rsp_type    rsp_data
);

   // A held result must keep its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   // Failed release results (bad index or idle worker) never name a worker.
   a_release_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_BAD_INDEX ||
                    rsp_data.status == STATUS_IDLE) |-> rsp_data.granted_worker == 3'd0)
      else $error("release result carries a nonzero worker");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input item accepted while another is in progress");

   // A new result only appears at the end of an item's processing.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item appeared without an item in progress");

endmodule

bind least_loaded_worker_dispatcher lld_checker u_lld_checker (.*);
